// File: sv/cbcp_pkg.sv
// ----------------------------------------------------------------------------
// cbcp_pkg
// Shared types and constants of the cigar block and clip parser.
// ----------------------------------------------------------------------------
package cbcp_pkg;

  localparam int POSITION_WIDTH = 32;

  localparam int OP_W     = 4;
  localparam int OPLEN_W  = 28;
  localparam int KIND_W   = 2;
  localparam int OUTPOS_W = 32;
  localparam int CLIP_W   = 2;
  localparam int THR_W    = 5;

  localparam logic [THR_W-1:0] CLIP_THRESHOLD_RST = 5'd15;

  // operation codes
  localparam logic [OP_W-1:0] OP_M = 4'd0;
  localparam logic [OP_W-1:0] OP_I = 4'd1;
  localparam logic [OP_W-1:0] OP_D = 4'd2;
  localparam logic [OP_W-1:0] OP_N = 4'd3;
  localparam logic [OP_W-1:0] OP_S = 4'd4;
  localparam logic [OP_W-1:0] OP_H = 4'd5;
  localparam logic [OP_W-1:0] OP_P = 4'd6;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_INSERT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BLOCK   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd3;

  // clip types
  localparam logic [CLIP_W-1:0] CLIP_NONE = 2'd0;
  localparam logic [CLIP_W-1:0] CLIP_SOFT = 2'd1;
  localparam logic [CLIP_W-1:0] CLIP_HARD = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [OUTPOS_W-1:0] position;
    logic [OUTPOS_W-1:0] length;
    logic                spliced;
    logic                chimeric;
    logic                clip_at_start;
    logic [CLIP_W-1:0]   clip_type;
    logic [OPLEN_W-1:0]  soft_clip_length;
    logic                last_result;
  } result_t;

endpackage

// File: sv/cbcp_if.sv
// ----------------------------------------------------------------------------
// cbcp channel interfaces
// Valid/ready channels for operations, results and the threshold register.
// ----------------------------------------------------------------------------
interface cbcp_in_if;
  logic                         valid;
  logic                         ready;
  logic [cbcp_pkg::OP_W-1:0]    op_code;
  logic [cbcp_pkg::OPLEN_W-1:0] op_length;
  logic                         is_last_op;

  modport source (output valid, op_code, op_length, is_last_op, input ready);
  modport sink   (input valid, op_code, op_length, is_last_op, output ready);
endinterface

interface cbcp_out_if;
  logic                          valid;
  logic                          ready;
  logic [cbcp_pkg::KIND_W-1:0]   kind;
  logic [cbcp_pkg::OUTPOS_W-1:0] position;
  logic [cbcp_pkg::OUTPOS_W-1:0] length;
  logic                          spliced;
  logic                          chimeric;
  logic                          clip_at_start;
  logic [cbcp_pkg::CLIP_W-1:0]   clip_type;
  logic [cbcp_pkg::OPLEN_W-1:0]  soft_clip_length;
  logic                          last_result;

  modport source (output valid, kind, position, length, spliced, chimeric, clip_at_start,
                  clip_type, soft_clip_length, last_result, input ready);
  modport sink   (input valid, kind, position, length, spliced, chimeric, clip_at_start,
                  clip_type, soft_clip_length, last_result, output ready);
endinterface

interface cbcp_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [cbcp_pkg::THR_W-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: sv/cigar_block_and_clip_parser.sv
// ----------------------------------------------------------------------------
// cigar_block_and_clip_parser
// Walks CIGAR operations, reports insertions, splice blocks and a summary, or an error.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch   takes one CIGAR operation per word (opcode, length, last flag).
//   out_ch  gives result words: insertion, block boundary, summary or error.
//           An operation gives zero, one or two words, the last one marked
//           by last_result.
//   cfg_ch  writes the soft clip threshold; always ready, write it only while
//           the block is idle.
// Results: the result words of an operation are written into the output queue
//   when it is accepted, and leave it in order.
// Throughput: one operation per cycle when not stalled. The alignment state is
//   updated in the accept cycle by one add and a few compares, and results go
//   into a four word output queue; the queue drains one word a cycle, so
//   operations that give two words average out against those that give none.
// Stall: when out_ch is held, the queue fills and in_ch.ready drops once
//   fewer than two free slots remain; nothing is lost or repeated.
// Reset: state returns to the start of an alignment, the queue empties and
//   the threshold goes back to 15.
// ----------------------------------------------------------------------------
module cigar_block_and_clip_parser #(
  parameter int POSITION_WIDTH = cbcp_pkg::POSITION_WIDTH
) (
  input  logic     clk,
  input  logic     rst_n,
  cbcp_in_if.sink  in_ch,
  cbcp_out_if.source out_ch,
  cbcp_cfg_if.sink cfg_ch
);

  localparam int PW    = POSITION_WIDTH;
  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = PTR_W + 1;

  // alignment state
  logic [PW-1:0]                    ref_r, ref_nxt;
  logic [PW-1:0]                    blk_r, blk_nxt;
  logic                             at_first_r, at_first_nxt;
  logic                             spliced_r, spliced_nxt;
  logic                             chim_r, chim_nxt;
  logic                             start_clip_r, start_clip_nxt;
  logic [cbcp_pkg::CLIP_W-1:0]      clip_kind_r, clip_kind_nxt;
  logic [cbcp_pkg::OPLEN_W-1:0]     scl_r, scl_nxt;
  logic [PW-1:0]                    last_ins_r, last_ins_nxt;
  logic                             ins_seen_r, ins_seen_nxt;
  logic [cbcp_pkg::THR_W-1:0]       thr_r;

  // result queue
  cbcp_pkg::result_t                fifo_r [DEPTH];
  logic [PTR_W-1:0]                 wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]                 cnt_r;

  logic                             in_fire, out_fire;
  cbcp_pkg::result_t                res0, res1, op_res;
  logic [1:0]                       n_push;
  logic [PW-1:0]                    len_ext, ins_pos, sum_pos;
  logic                             op_has_res, err, is_clip;
  logic [cbcp_pkg::CLIP_W-1:0]      clip_type_in;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (cnt_r <= CNT_W'(DEPTH - 2));
  assign cfg_ch.ready = 1'b1;

  assign len_ext = PW'(in_ch.op_length);
  assign ins_pos = ref_r + PW'(1);
  assign sum_pos = ref_r + len_ext;

  always_comb begin
    ref_nxt        = ref_r;
    blk_nxt        = blk_r;
    at_first_nxt   = at_first_r;
    spliced_nxt    = spliced_r;
    chim_nxt       = chim_r;
    start_clip_nxt = start_clip_r;
    clip_kind_nxt  = clip_kind_r;
    scl_nxt        = scl_r;
    last_ins_nxt   = last_ins_r;
    ins_seen_nxt   = ins_seen_r;
    op_has_res     = 1'b0;
    err            = 1'b0;
    is_clip        = 1'b0;
    clip_type_in   = cbcp_pkg::CLIP_NONE;
    op_res         = '0;
    res0           = '0;
    res1           = '0;
    n_push         = 2'd0;

    case (in_ch.op_code)
      cbcp_pkg::OP_M, cbcp_pkg::OP_D: begin
        blk_nxt = blk_r + len_ext;
        ref_nxt = sum_pos;
      end
      cbcp_pkg::OP_I: begin
        // repeated insertion at the same position is dropped
        if (!(ins_seen_r && last_ins_r == ins_pos)) begin
          op_has_res      = 1'b1;
          op_res.kind     = cbcp_pkg::KIND_INSERT;
          op_res.position = cbcp_pkg::OUTPOS_W'(ins_pos);
          op_res.length   = cbcp_pkg::OUTPOS_W'(in_ch.op_length);
          ins_seen_nxt    = 1'b1;
          last_ins_nxt    = ins_pos;
        end
      end
      cbcp_pkg::OP_N: begin
        op_has_res      = 1'b1;
        op_res.kind     = cbcp_pkg::KIND_BLOCK;
        op_res.position = cbcp_pkg::OUTPOS_W'(sum_pos);
        op_res.length   = cbcp_pkg::OUTPOS_W'(blk_r);
        spliced_nxt     = 1'b1;
        ref_nxt         = sum_pos;
        blk_nxt         = '0;
      end
      cbcp_pkg::OP_S: begin
        if (ref_r == '0) begin
          scl_nxt = in_ch.op_length;
        end
        is_clip      = (in_ch.op_length >= cbcp_pkg::OPLEN_W'(thr_r));
        clip_type_in = cbcp_pkg::CLIP_SOFT;
      end
      cbcp_pkg::OP_H: begin
        is_clip      = 1'b1;
        clip_type_in = cbcp_pkg::CLIP_HARD;
      end
      cbcp_pkg::OP_P: begin
      end
      default: begin
        err = 1'b1;
      end
    endcase

    // end clips: the clip type of a last operation wins over that of the first
    if (is_clip && (at_first_r || in_ch.is_last_op)) begin
      chim_nxt      = 1'b1;
      clip_kind_nxt = clip_type_in;
      if (at_first_r) begin
        start_clip_nxt = 1'b1;
      end
    end
    at_first_nxt = 1'b0;

    // flags as they stand after this operation
    op_res.spliced          = spliced_nxt;
    op_res.chimeric         = chim_nxt;
    op_res.clip_at_start    = start_clip_nxt;
    op_res.clip_type        = clip_kind_nxt;
    op_res.soft_clip_length = scl_nxt;

    if (err) begin
      res0             = '0;
      res0.kind        = cbcp_pkg::KIND_ERROR;
      res0.last_result = 1'b1;
      n_push           = 2'd1;
    end else begin
      res1             = op_res;
      res1.kind        = cbcp_pkg::KIND_SUMMARY;
      res1.position    = cbcp_pkg::OUTPOS_W'(ref_nxt);
      res1.length      = cbcp_pkg::OUTPOS_W'(blk_nxt);
      res1.last_result = 1'b1;
      if (op_has_res) begin
        res0             = op_res;
        res0.last_result = !in_ch.is_last_op;
        n_push           = in_ch.is_last_op ? 2'd2 : 2'd1;
      end else if (in_ch.is_last_op) begin
        res0   = res1;
        n_push = 2'd1;
      end
    end

    if (err || in_ch.is_last_op) begin
      ref_nxt        = '0;
      blk_nxt        = '0;
      at_first_nxt   = 1'b1;
      spliced_nxt    = 1'b0;
      chim_nxt       = 1'b0;
      start_clip_nxt = 1'b0;
      clip_kind_nxt  = cbcp_pkg::CLIP_NONE;
      scl_nxt        = '0;
      last_ins_nxt   = '0;
      ins_seen_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r        <= '0;
      blk_r        <= '0;
      at_first_r   <= 1'b1;
      spliced_r    <= 1'b0;
      chim_r       <= 1'b0;
      start_clip_r <= 1'b0;
      clip_kind_r  <= cbcp_pkg::CLIP_NONE;
      scl_r        <= '0;
      last_ins_r   <= '0;
      ins_seen_r   <= 1'b0;
      thr_r        <= cbcp_pkg::CLIP_THRESHOLD_RST;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      cnt_r        <= '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        thr_r <= cfg_ch.data;
      end
      if (in_fire) begin
        ref_r        <= ref_nxt;
        blk_r        <= blk_nxt;
        at_first_r   <= at_first_nxt;
        spliced_r    <= spliced_nxt;
        chim_r       <= chim_nxt;
        start_clip_r <= start_clip_nxt;
        clip_kind_r  <= clip_kind_nxt;
        scl_r        <= scl_nxt;
        last_ins_r   <= last_ins_nxt;
        ins_seen_r   <= ins_seen_nxt;
        wr_ptr_r     <= wr_ptr_r + PTR_W'(n_push);
      end
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      cnt_r <= cnt_r + (in_fire ? CNT_W'(n_push) : CNT_W'(0)) - CNT_W'(out_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && n_push != 2'd0) begin
      fifo_r[wr_ptr_r] <= res0;
    end
    if (in_fire && n_push == 2'd2) begin
      fifo_r[wr_ptr_r + PTR_W'(1)] <= res1;
    end
  end

  assign out_ch.valid            = (cnt_r != '0);
  assign out_ch.kind             = fifo_r[rd_ptr_r].kind;
  assign out_ch.position         = fifo_r[rd_ptr_r].position;
  assign out_ch.length           = fifo_r[rd_ptr_r].length;
  assign out_ch.spliced          = fifo_r[rd_ptr_r].spliced;
  assign out_ch.chimeric         = fifo_r[rd_ptr_r].chimeric;
  assign out_ch.clip_at_start    = fifo_r[rd_ptr_r].clip_at_start;
  assign out_ch.clip_type        = fifo_r[rd_ptr_r].clip_type;
  assign out_ch.soft_clip_length = fifo_r[rd_ptr_r].soft_clip_length;
  assign out_ch.last_result      = fifo_r[rd_ptr_r].last_result;

  // queue never overflows
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("result queue overflow");

  // last operation leaves a fresh alignment
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.is_last_op |=> at_first_r && ref_r == '0 && !ins_seen_r)
    else $error("state not cleared after last operation");

  // summary and error words always close an operation
  a_final_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.kind == cbcp_pkg::KIND_SUMMARY ||
                     out_ch.kind == cbcp_pkg::KIND_ERROR) |-> out_ch.last_result)
    else $error("summary or error word without last_result");

  // error words carry no position, length or flags
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.kind == cbcp_pkg::KIND_ERROR |->
      out_ch.position == '0 && out_ch.length == '0 && !out_ch.chimeric &&
      !out_ch.spliced)
    else $error("error word with nonzero fields");

endmodule
